FILE: design/multidrop_frame_receiver_top_defines.svh
// Assertion macros shared by the receiver's RTL files.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef MULTIDROP_FRAME_RECEIVER_TOP_DEFINES_SVH
`define MULTIDROP_FRAME_RECEIVER_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define MFR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define MFR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/mfr_pkg.sv
package mfr_pkg;

  // Number of data characters a frame may occupy (length, payload and CRC).
  localparam int FRAME_BUFFER_BYTES = 128;
  // Length byte plus two CRC bytes.
  localparam int FRAME_OVERHEAD = 3;

  // Width of the data character counter; it must reach FRAME_BUFFER_BYTES.
  localparam int CNT_W = $clog2(FRAME_BUFFER_BYTES + 1);
  // Width used for position compares; holds the bound and the length plus two.
  localparam int CMP_W = 10;

  localparam logic [15:0] CRC_POLY       = 16'hA001;
  localparam logic [15:0] CRC_SEED       = 16'h0000;
  localparam logic [7:0]  BCAST_ADDR     = 8'h00;
  localparam logic [7:0]  OWN_ADDR_RESET = 8'h01;

  // Result kinds.
  localparam logic KIND_PAYLOAD   = 1'b0;
  localparam logic KIND_FRAME_END = 1'b1;

  // One received character.
  typedef struct packed {
    logic [7:0] rx_byte;
    logic       ninth_bit;
    logic       line_error;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic       result_kind;
    logic [7:0] payload_byte;
    logic [7:0] payload_index;
    logic       crc_ok;
    logic       is_broadcast;
  } out_item_t;

  // Result of the frame logic for the character leaving the input register.
  typedef struct packed {
    logic      valid;
    out_item_t item;
  } result_t;

  // Byte-wide CRC-16/ARC update, LSB first.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

FILE: design/mfr_ifs.sv
// Received character channel.
interface mfr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       ninth_bit;
  logic       line_error;

  modport source (output valid, output rx_byte, output ninth_bit, output line_error,
                  input ready);
  modport sink (input valid, input rx_byte, input ninth_bit, input line_error,
                output ready);
endinterface

// Result channel.
interface mfr_out_if;
  logic       valid;
  logic       ready;
  logic       result_kind;
  logic [7:0] payload_byte;
  logic [7:0] payload_index;
  logic       crc_ok;
  logic       is_broadcast;

  modport source (output valid, output result_kind, output payload_byte,
                  output payload_index, output crc_ok, output is_broadcast,
                  input ready);
  modport sink (input valid, input result_kind, input payload_byte,
                input payload_index, input crc_ok, input is_broadcast,
                output ready);
endinterface

FILE: design/mfr_in_stage.sv
module mfr_in_stage (
  input  logic              clk,
  input  logic              rst_n,
  mfr_in_if.sink            in_ch,
  input  logic              advance,
  output logic              item_valid,
  output mfr_pkg::in_item_t item
);

  logic              valid_r;
  logic              valid_nxt;
  mfr_pkg::in_item_t item_r;
  logic              take;

  // A new item enters when the register is empty or its item moves on now.
  assign in_ch.ready = !valid_r || advance;
  assign take        = in_ch.valid && in_ch.ready;

  always_comb begin
    if (take) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload register, no reset needed.
  always_ff @(posedge clk) begin
    if (take) begin
      item_r.rx_byte    <= in_ch.rx_byte;
      item_r.ninth_bit  <= in_ch.ninth_bit;
      item_r.line_error <= in_ch.line_error;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

FILE: design/mfr_core.sv
module mfr_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [7:0]        cfg_wdata,
  input  logic              step,
  input  mfr_pkg::in_item_t item,
  output mfr_pkg::result_t  res
);

  logic [7:0]                own_address_r;
  logic                      in_frame_r,  in_frame_nxt;
  logic [7:0]                len_r,       len_nxt;
  logic [mfr_pkg::CNT_W-1:0] taken_r,     taken_nxt;
  logic [15:0]               crc_r,       crc_nxt;
  logic [7:0]                prev_r,      prev_nxt;
  logic                      bcast_r,     bcast_nxt;

  logic [mfr_pkg::CMP_W-1:0] pos_w;
  logic [mfr_pkg::CMP_W-1:0] last_w;
  logic [mfr_pkg::CMP_W-1:0] idx_w;
  logic [15:0]               crc_upd;
  logic                      addr_match;

  // Node address register; the user must write it only while the block is idle, the block does not enforce it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_address_r <= mfr_pkg::OWN_ADDR_RESET;
    end else if (cfg_we) begin
      own_address_r <= cfg_wdata;
    end
  end

  // Position arithmetic in a common width.
  assign pos_w   = mfr_pkg::CMP_W'(taken_r);
  assign last_w  = mfr_pkg::CMP_W'(len_r) + mfr_pkg::CMP_W'(mfr_pkg::FRAME_OVERHEAD - 1);
  assign idx_w   = pos_w - mfr_pkg::CMP_W'(1);
  assign crc_upd = mfr_pkg::crc_byte(crc_r, item.rx_byte);

  assign addr_match = (item.rx_byte == own_address_r) ||
                      (item.rx_byte == mfr_pkg::BCAST_ADDR);

  // Frame decoding for the character leaving the input register.
  always_comb begin
    in_frame_nxt = in_frame_r;
    len_nxt      = len_r;
    taken_nxt    = taken_r;
    crc_nxt      = crc_r;
    prev_nxt     = prev_r;
    bcast_nxt    = bcast_r;

    res.valid              = 1'b0;
    res.item.result_kind   = mfr_pkg::KIND_PAYLOAD;
    res.item.payload_byte  = 8'h00;
    res.item.payload_index = 8'h00;
    res.item.crc_ok        = 1'b0;
    res.item.is_broadcast  = bcast_r;

    if (step && !item.line_error) begin
      priority if (item.ninth_bit) begin
        // Address character: open a frame or close reception.
        if (addr_match) begin
          in_frame_nxt = 1'b1;
          taken_nxt    = '0;
          crc_nxt      = mfr_pkg::crc_byte(mfr_pkg::CRC_SEED, item.rx_byte);
          bcast_nxt    = (item.rx_byte == mfr_pkg::BCAST_ADDR);
        end else begin
          in_frame_nxt = 1'b0;
        end
      end else if (in_frame_r &&
                   (pos_w < mfr_pkg::CMP_W'(mfr_pkg::FRAME_BUFFER_BYTES))) begin
        taken_nxt = taken_r + mfr_pkg::CNT_W'(1);
        prev_nxt  = item.rx_byte;
        priority if (pos_w == '0) begin
          // Length byte.
          len_nxt = item.rx_byte;
          crc_nxt = crc_upd;
        end else if (pos_w <= mfr_pkg::CMP_W'(len_r)) begin
          // Payload byte, passed on unverified.
          crc_nxt                = crc_upd;
          res.valid              = 1'b1;
          res.item.payload_byte  = item.rx_byte;
          res.item.payload_index = idx_w[7:0];
        end else if (pos_w == last_w) begin
          // CRC high byte closes the frame.
          res.valid              = 1'b1;
          res.item.result_kind   = mfr_pkg::KIND_FRAME_END;
          res.item.payload_index = len_r;
          res.item.crc_ok        = ({item.rx_byte, prev_r} == crc_r);
          in_frame_nxt           = 1'b0;
          crc_nxt                = mfr_pkg::CRC_SEED;
        end else begin
          // CRC low byte: only remembered.
          prev_nxt = item.rx_byte;
        end
      end else begin
        // Data outside a frame or beyond the buffer bound.
        taken_nxt = taken_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      len_r      <= '0;
      taken_r    <= '0;
      crc_r      <= mfr_pkg::CRC_SEED;
      prev_r     <= '0;
      bcast_r    <= 1'b0;
    end else begin
      in_frame_r <= in_frame_nxt;
      len_r      <= len_nxt;
      taken_r    <= taken_nxt;
      crc_r      <= crc_nxt;
      prev_r     <= prev_nxt;
      bcast_r    <= bcast_nxt;
    end
  end

endmodule

FILE: design/mfr_out_stage.sv
module mfr_out_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  mfr_pkg::result_t  res,
  input  logic              advance,
  output logic              can_take,
  mfr_out_if.source         out_ch
);

  logic               valid_r;
  logic               valid_nxt;
  mfr_pkg::out_item_t item_r;
  logic               load;

  // The register can take a result when empty or being emptied this cycle.
  assign can_take = !valid_r || out_ch.ready;
  assign load     = advance && res.valid;

  always_comb begin
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= res.item;
    end
  end

  assign out_ch.valid         = valid_r;
  assign out_ch.result_kind   = item_r.result_kind;
  assign out_ch.payload_byte  = item_r.payload_byte;
  assign out_ch.payload_index = item_r.payload_index;
  assign out_ch.crc_ok        = item_r.crc_ok;
  assign out_ch.is_broadcast  = item_r.is_broadcast;

endmodule

FILE: design/multidrop_frame_receiver_top.sv
// Multidrop frame receiver: takes 9-bit UART characters and streams out the
// payload bytes of frames addressed to the configured own address or to
// broadcast zero, then one frame-end item with the CRC-16/ARC check result.
// One character is accepted every clock cycle as long as the result side
// keeps taking items; an accepted character is loaded into the input
// register and, once the result register can take it, carries on through
// the frame logic into the result register, which offers the result.
// The only thing that slows intake is a stalled result register.
// Write the own address only while no character is in flight.
`include "multidrop_frame_receiver_top_defines.svh"

module multidrop_frame_receiver_top (
  input  logic       clk,
  input  logic       rst_n,
  mfr_in_if.sink     in_ch,
  mfr_out_if.source  out_ch,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata
);

  logic              in_valid;
  mfr_pkg::in_item_t in_item;
  mfr_pkg::result_t  res;
  logic              can_take;
  logic              advance;

  // The buffered character moves on when the result register can take it.
  assign advance = in_valid && can_take;

  mfr_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .advance    (advance),
    .item_valid (in_valid),
    .item       (in_item)
  );

  mfr_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .step      (advance),
    .item      (in_item),
    .res       (res)
  );

  mfr_out_stage u_out_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .res      (res),
    .advance  (advance),
    .can_take (can_take),
    .out_ch   (out_ch)
  );

  // A held character with a stalled result register blocks intake.
  `MFR_ASSERT_NOW(a_no_intake_when_full, in_valid && out_ch.valid && !out_ch.ready, !in_ch.ready, "intake while full")
  // A produced result is registered and shows up at the output.
  `MFR_ASSERT_NEXT(a_result_lands, advance && res.valid, out_ch.valid, "result lost")
  // A payload item never claims a CRC match.
  `MFR_ASSERT_NOW(a_payload_no_crc, out_ch.valid && (out_ch.result_kind == mfr_pkg::KIND_PAYLOAD), !out_ch.crc_ok, "crc_ok on payload")

endmodule
